FILE: rtl/saes_cbc_cipher_assert.svh
// ----------------------------------------------------------------------------
// S-AES CBC cipher assertion macros
// Shared property macros for the concurrent checks of the cipher block.
// ----------------------------------------------------------------------------
`ifndef SAES_CBC_CIPHER_ASSERT_SVH
`define SAES_CBC_CIPHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/saes_pkg.sv
// ----------------------------------------------------------------------------
// S-AES package
// Constants, types and the nibble-level cipher functions of the S-AES core.
// ----------------------------------------------------------------------------
package saes_pkg;

   localparam logic [4:0] GfPoly = 5'h13;
   localparam logic [7:0] RcOne  = 8'h80;
   localparam logic [7:0] RcTwo  = 8'h30;

   // Mixing coefficients for the forward and inverse column mix.
   localparam logic [3:0] MixDiag    = 4'h1;
   localparam logic [3:0] MixOff     = 4'h4;
   localparam logic [3:0] InvMixDiag = 4'h9;
   localparam logic [3:0] InvMixOff  = 4'h2;

   // Command codes of the input transfer.
   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   // Register indexes on the configuration port.
   localparam logic RegCipherKey  = 1'b0;
   localparam logic RegInitVector = 1'b1;

   // Key and both round keys, travelling together.
   typedef struct packed {
      logic [15:0] k0;
      logic [15:0] k1;
      logic [15:0] k2;
   } saes_keys_type;

   function automatic logic [3:0] sub_nib(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'h9;  4'h1: r = 4'h4;  4'h2: r = 4'hA;  4'h3: r = 4'hB;
         4'h4: r = 4'hD;  4'h5: r = 4'h1;  4'h6: r = 4'h8;  4'h7: r = 4'h5;
         4'h8: r = 4'h6;  4'h9: r = 4'h2;  4'hA: r = 4'h0;  4'hB: r = 4'h3;
         4'hC: r = 4'hC;  4'hD: r = 4'hE;  4'hE: r = 4'hF;  4'hF: r = 4'h7;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] unsub_nib(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'hA;  4'h1: r = 4'h5;  4'h2: r = 4'h9;  4'h3: r = 4'hB;
         4'h4: r = 4'h1;  4'h5: r = 4'h7;  4'h6: r = 4'h8;  4'h7: r = 4'hF;
         4'h8: r = 4'h6;  4'h9: r = 4'h0;  4'hA: r = 4'h2;  4'hB: r = 4'h3;
         4'hC: r = 4'hC;  4'hD: r = 4'h4;  4'hE: r = 4'hD;  4'hF: r = 4'hE;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sub_word(input logic [15:0] s);
      return {sub_nib(s[15:12]), sub_nib(s[11:8]), sub_nib(s[7:4]), sub_nib(s[3:0])};
   endfunction

   function automatic logic [15:0] unsub_word(input logic [15:0] s);
      return {unsub_nib(s[15:12]), unsub_nib(s[11:8]),
              unsub_nib(s[7:4]), unsub_nib(s[3:0])};
   endfunction

   // Swaps nibbles one and three; it is its own inverse.
   function automatic logic [15:0] swap_row(input logic [15:0] s);
      return {s[15:12], s[3:0], s[7:4], s[11:8]};
   endfunction

   // Multiplication in GF(2^4) modulo x^4+x+1.
   function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      logic [4:0] sh;
      acc = 4'h0;
      sh  = {1'b0, a};
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            acc = acc ^ sh[3:0];
         end
         sh = {sh[3:0], 1'b0};
         if (sh[4]) begin
            sh = sh ^ GfPoly;
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] mix_word(input logic [15:0] s, input logic [3:0] diag,
                                            input logic [3:0] off);
      logic [3:0] a, b, c, d;
      a = s[15:12];
      b = s[11:8];
      c = s[7:4];
      d = s[3:0];
      return {gf_mul(diag, a) ^ gf_mul(off, b), gf_mul(off, a) ^ gf_mul(diag, b),
              gf_mul(diag, c) ^ gf_mul(off, d), gf_mul(off, c) ^ gf_mul(diag, d)};
   endfunction

   // One key expansion step: RotNib, SubNib and the round constant.
   function automatic logic [15:0] next_key(input logic [15:0] k, input logic [7:0] rc);
      logic [7:0] rs;
      logic [7:0] n_hi;
      rs   = {sub_nib(k[3:0]), sub_nib(k[7:4])};
      n_hi = k[15:8] ^ rc ^ rs;
      return {n_hi, n_hi ^ k[7:0]};
   endfunction

   function automatic saes_keys_type expand_key(input logic [15:0] k);
      saes_keys_type r;
      r.k0 = k;
      r.k1 = next_key(k, RcOne);
      r.k2 = next_key(r.k1, RcTwo);
      return r;
   endfunction

endpackage

FILE: rtl/saes_csr.sv
// ----------------------------------------------------------------------------
// S-AES configuration registers
// APB-style register file holding the key, its expanded round keys and the IV.
// ----------------------------------------------------------------------------
module saes_csr import saes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready,
   output saes_keys_type keys,
   output logic [15:0]   init_vector
);

   saes_keys_type keys_ff;
   logic [15:0]   init_vector_ff;
   logic          wr_en;
   logic          reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // The round keys are expanded when the key is written.
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff        <= expand_key(16'h0000);
         init_vector_ff <= 16'h0000;
      end else if (wr_en) begin
         case (reg_sel)
            RegCipherKey:  keys_ff        <= expand_key(pwdata[15:0]);
            RegInitVector: init_vector_ff <= pwdata[15:0];
            default:       init_vector_ff <= init_vector_ff;
         endcase
      end
   end

   // Read data comes straight from the registers.
   always_comb begin
      case (reg_sel)
         RegCipherKey:  prdata = {16'h0000, keys_ff.k0};
         RegInitVector: prdata = {16'h0000, init_vector_ff};
         default:       prdata = 32'h0000_0000;
      endcase
   end

   assign keys        = keys_ff;
   assign init_vector = init_vector_ff;

endmodule

FILE: rtl/saes_block_core.sv
// ----------------------------------------------------------------------------
// S-AES block core
// Two-round S-AES encrypt or decrypt of one block with the CBC chaining XOR.
// ----------------------------------------------------------------------------
module saes_block_core import saes_pkg::*; (
   input  logic          command,
   input  logic [15:0]   data_block,
   input  logic [15:0]   prev_block,
   input  saes_keys_type keys,
   output logic [15:0]   result_block,
   output logic [15:0]   chain_next
);

   logic [15:0] enc_s0, enc_s1, enc_out;
   logic [15:0] dec_s0, dec_s1, dec_s2, dec_out;

   // Forward cipher on the plaintext XORed with the chain value.
   always_comb begin
      enc_s0  = data_block ^ prev_block ^ keys.k0;
      enc_s1  = mix_word(swap_row(sub_word(enc_s0)), MixDiag, MixOff) ^ keys.k1;
      enc_out = swap_row(sub_word(enc_s1)) ^ keys.k2;
   end

   // Inverse cipher, then the chain value is removed.
   always_comb begin
      dec_s0  = data_block ^ keys.k2;
      dec_s1  = unsub_word(swap_row(dec_s0)) ^ keys.k1;
      dec_s2  = mix_word(dec_s1, InvMixDiag, InvMixOff);
      dec_out = unsub_word(swap_row(dec_s2)) ^ keys.k0 ^ prev_block;
   end

   // The chain always continues from the ciphertext side of the block.
   always_comb begin
      case (command)
         CmdEncrypt: begin
            result_block = enc_out;
            chain_next   = enc_out;
         end
         CmdDecrypt: begin
            result_block = dec_out;
            chain_next   = data_block;
         end
         default: begin
            result_block = enc_out;
            chain_next   = enc_out;
         end
      endcase
   end

endmodule

FILE: rtl/saes_cbc_cipher.sv
// ----------------------------------------------------------------------------
// S-AES CBC cipher
// 16-bit S-AES with a 16-bit key in CBC mode, one block per cycle unless stalled.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake             Payload
//   req       in          req_valid/req_stall   command, data_block, first_block
//   rsp       out         rsp_valid/rsp_stall   result_block
//   csr       in/out      APB-style             cipher_key, init_vector
//
// A block is taken into the input register, passes the combinational cipher
// logic and lands in the result register.
// One block per cycle is sustained while the result side does not stall; the
// chain register closes the CBC loop through the combinational cipher logic.
// Reset clears the chain value, key and IV to zero.
// A stall on the result side holds both stages and backs up onto req_stall.
// ----------------------------------------------------------------------------
module saes_cbc_cipher import saes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_data_block,
   input  logic        req_first_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_block,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "saes_cbc_cipher_assert.svh"

   saes_keys_type keys;
   logic [15:0]   init_vector;

   logic          stage_valid_ff, stage_valid_in;
   logic          stage_cmd_ff;
   logic [15:0]   stage_data_ff;
   logic          stage_first_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_block_ff;
   logic [15:0]   chain_ff;
   logic          advance;
   logic [15:0]   prev_block;
   logic [15:0]   core_result;
   logic [15:0]   core_chain;

   saes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .keys        (keys),
      .init_vector (init_vector)
   );

   // Handshake: the input stage moves on when the result register is empty or its result is taken.
   assign advance        = stage_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall      = stage_valid_ff & rsp_valid_ff & rsp_stall;
   assign stage_valid_in = req_stall ? stage_valid_ff : req_valid;
   assign rsp_valid_in   = advance | (rsp_valid_ff & rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         stage_cmd_ff   <= req_command;
         stage_data_ff  <= req_data_block;
         stage_first_ff <= req_first_block;
      end
   end

   // Restart selects the IV, otherwise the previous ciphertext.
   assign prev_block = stage_first_ff ? init_vector : chain_ff;

   saes_block_core u_core (
      .command      (stage_cmd_ff),
      .data_block   (stage_data_ff),
      .prev_block   (prev_block),
      .keys         (keys),
      .result_block (core_result),
      .chain_next   (core_chain)
   );

   // Chain value and result register update together.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chain_ff     <= 16'h0000;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            chain_ff <= core_chain;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_block_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;

   // Checks on the stage and chain logic.
   `SAES_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, stage_valid_ff,
      "input stalled with an empty stage")
   `SAES_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, rsp_valid_ff,
      "stage advanced without a result")
   `SAES_ASSERT_NEXT(a_enc_chain, clock, reset, advance && (stage_cmd_ff == CmdEncrypt),
      chain_ff == rsp_block_ff, "encrypt chain differs from ciphertext")
   `SAES_ASSERT_NEXT(a_dec_chain, clock, reset, advance && (stage_cmd_ff == CmdDecrypt),
      chain_ff == $past(stage_data_ff), "decrypt chain differs from input block")

endmodule
